[hw/rtl/h264_rtp_depacketizer_core_macros.svh]
// assertion macros for the h264 rtp depacketizer
// used by the core top level, no other dependencies
`ifndef H264_RTP_DEPACKETIZER_CORE_MACROS_SVH
`define H264_RTP_DEPACKETIZER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define H264RD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("h264rd assertion failed");
// next-cycle implication
`define H264RD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("h264rd assertion failed");
`else
`define H264RD_ASSERT_NOW(label, clk, rstn, ante, cons)
`define H264RD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/h264rd_pkg.sv]
// shared types, constants and helpers of the h264 rtp depacketizer
// no dependencies
package h264rd_pkg;

    localparam int unsigned OffsetBitsDefault = 16;
    localparam int unsigned MaxResults        = 8;
    localparam int unsigned QueueDepth        = 16;
    localparam logic [23:0] MaxFrameReset     = 24'd1048576;

    // packet status codes
    localparam logic [2:0] ST_COMPLETE  = 3'd0;
    localparam logic [2:0] ST_CONTINUES = 3'd1;
    localparam logic [2:0] ST_BAD_LEN   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd0;

    // result kinds
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // nal unit types
    localparam logic [4:0] NAL_STAP_A = 5'd24;
    localparam logic [4:0] NAL_FU_A   = 5'd28;

    typedef enum logic [1:0] {
        PK_IDLE   = 2'd0,
        PK_SINGLE = 2'd1,
        PK_STAP   = 2'd2,
        PK_FU     = 2'd3
    } pkt_kind_t;

    typedef enum logic [1:0] {
        PH_SIZE_HI = 2'd0,
        PH_SIZE_LO = 2'd1,
        PH_DATA    = 2'd2,
        PH_SPARE   = 2'd3
    } agg_phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       frame_start;
        logic [2:0] status;
        logic       last;
    } res_t;

    // short start code choice from the first two unit bytes
    function automatic logic use_short(input logic [7:0] b0, input logic [7:0] b1);
        use_short = (b0 == 8'h65) || (((b0 == 8'h61) || (b0 == 8'h41)) && !b1[7]);
    endfunction

endpackage

[hw/rtl/h264rd_parse.sv]
// packet parser: state registers and per-byte result generation
// depends on h264rd_pkg
module h264rd_parse #(
    parameter int unsigned PACKET_OFFSET_BITS = h264rd_pkg::OffsetBitsDefault
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            in_byte,
    input  logic                  in_first,
    input  logic                  in_last,
    input  logic [23:0]           max_frame,
    output h264rd_pkg::res_t      res [h264rd_pkg::MaxResults],
    output logic [3:0]            res_cnt
);
    import h264rd_pkg::*;

    localparam logic [PACKET_OFFSET_BITS-1:0] OffMax = '1;
    localparam logic [PACKET_OFFSET_BITS-1:0] Off1 = PACKET_OFFSET_BITS'(1);
    localparam logic [PACKET_OFFSET_BITS-1:0] Off2 = PACKET_OFFSET_BITS'(2);
    localparam logic [PACKET_OFFSET_BITS-1:0] Off3 = PACKET_OFFSET_BITS'(3);

    pkt_kind_t                   kind_reg, kind_next;
    agg_phase_t                  ph_reg, ph_next;
    logic [PACKET_OFFSET_BITS-1:0] off_reg, off_next;
    logic [7:0]  hi_reg, hi_next, hh_reg, hh_next, hu_reg, hu_next;
    logic [15:0] es_reg, es_next, el_reg, el_next;
    logic [23:0] fc_reg, fc_next;
    logic [2:0]  pend_reg, pend_next;

    logic [2:0]  code_len;
    logic [7:0]  dv [3];
    logic [1:0]  dn;
    logic [2:0]  ntot, ne;
    logic [24:0] room;
    logic        fs0, has_status;
    logic [2:0]  st;
    logic [7:0]  nal;
    logic [15:0] pos;
    logic [2:0]  idx;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= PK_IDLE;
            ph_reg   <= PH_SIZE_HI;
            off_reg  <= '0;
            hi_reg   <= '0;
            hh_reg   <= '0;
            hu_reg   <= '0;
            es_reg   <= '0;
            el_reg   <= '0;
            fc_reg   <= '0;
            pend_reg <= ST_NONE;
        end else if (step) begin
            kind_reg <= kind_next;
            ph_reg   <= ph_next;
            off_reg  <= off_next;
            hi_reg   <= hi_next;
            hh_reg   <= hh_next;
            hu_reg   <= hu_next;
            es_reg   <= es_next;
            el_reg   <= el_next;
            fc_reg   <= fc_next;
            pend_reg <= pend_next;
        end
    end

    // next state, candidate bytes and results for one payload byte
    always_comb begin
        kind_next = kind_reg;
        ph_next   = ph_reg;
        off_next  = off_reg;
        hi_next   = hi_reg;
        hh_next   = hh_reg;
        hu_next   = hu_reg;
        es_next   = es_reg;
        el_next   = el_reg;
        fc_next   = fc_reg;
        pend_next = pend_reg;
        code_len  = 3'd0;
        dv[0]     = 8'h00;
        dv[1]     = 8'h00;
        dv[2]     = 8'h00;
        dn        = 2'd0;
        has_status = 1'b0;
        st        = ST_COMPLETE;
        nal       = (hi_reg & 8'he0) | (hh_reg & 8'h1f);
        pos       = es_reg - el_reg;

        if (in_first) begin
            // packet header byte
            off_next  = '0;
            pend_next = ST_NONE;
            hh_next   = 8'h00;
            if (in_byte[4:0] <= 5'd23) begin
                kind_next = PK_SINGLE;
                fc_next   = '0;
                hu_next   = in_byte;
                if (in_last) begin
                    code_len = use_short(in_byte, 8'h00) ? 3'd3 : 3'd4;
                    dv[0] = in_byte;
                    dn    = 2'd1;
                end
            end else if (in_byte[4:0] == NAL_STAP_A) begin
                kind_next = PK_STAP;
                fc_next   = '0;
                ph_next   = PH_SIZE_HI;
                es_next   = '0;
                el_next   = '0;
            end else if (in_byte[4:0] == NAL_FU_A) begin
                kind_next = PK_FU;
                hi_next   = in_byte;
            end else begin
                kind_next = PK_SINGLE;
                fc_next   = '0;
                pend_next = ST_UNKNOWN;
            end
        end else if (kind_reg != PK_IDLE) begin
            if (off_reg < OffMax) off_next = off_reg + Off1;
            if (pend_reg == ST_NONE) begin
                case (kind_reg)
                    // single nal unit
                    PK_SINGLE: begin
                        if (off_next == Off1) begin
                            code_len = use_short(hu_reg, in_byte) ? 3'd3 : 3'd4;
                            dv[0] = hu_reg;
                            dv[1] = in_byte;
                            dn    = 2'd2;
                        end else begin
                            dv[0] = in_byte;
                            dn    = 2'd1;
                        end
                    end
                    // aggregation packet
                    PK_STAP: begin
                        if (ph_reg == PH_SIZE_HI) begin
                            es_next = {in_byte, 8'h00};
                            ph_next = PH_SIZE_LO;
                        end else if (ph_reg == PH_SIZE_LO) begin
                            es_next = es_reg | {8'h00, in_byte};
                            ph_next = PH_SIZE_HI;
                            if (!in_last) begin
                                if (es_next == 16'd0) begin
                                    code_len = 3'd4;
                                end else begin
                                    el_next = es_next;
                                    ph_next = PH_DATA;
                                end
                            end
                        end else begin
                            if (pos == 16'd0) begin
                                hu_next = in_byte;
                                if (es_reg == 16'd1) begin
                                    code_len = use_short(in_byte, 8'h00) ? 3'd3 : 3'd4;
                                    dv[0] = in_byte;
                                    dn    = 2'd1;
                                end
                            end else if (pos == 16'd1) begin
                                code_len = use_short(hu_reg, in_byte) ? 3'd3 : 3'd4;
                                dv[0] = hu_reg;
                                dv[1] = in_byte;
                                dn    = 2'd2;
                            end else begin
                                dv[0] = in_byte;
                                dn    = 2'd1;
                            end
                            el_next = el_reg - 16'd1;
                            if (el_next == 16'd0) ph_next = PH_SIZE_HI;
                        end
                    end
                    // fragmentation unit
                    PK_FU: begin
                        if (off_next == Off1) begin
                            hh_next = in_byte;
                            if (in_byte[7]) fc_next = '0;
                        end else if (!hh_reg[7]) begin
                            dv[0] = in_byte;
                            dn    = 2'd1;
                        end else if (off_next == Off2) begin
                            hu_next = in_byte;
                            if (in_last) begin
                                code_len = use_short(in_byte, 8'h00) ? 3'd3 : 3'd4;
                                dv[0] = nal;
                                dv[1] = in_byte;
                                dn    = 2'd2;
                            end
                        end else if (off_next == Off3) begin
                            code_len = use_short(hu_reg, in_byte) ? 3'd3 : 3'd4;
                            dv[0] = nal;
                            dv[1] = hu_reg;
                            dv[2] = in_byte;
                            dn    = 2'd3;
                        end else begin
                            dv[0] = in_byte;
                            dn    = 2'd1;
                        end
                    end
                    default: begin
                        dn = 2'd0;
                    end
                endcase
            end
        end

        // frame size limit: how many candidate bytes go out
        ntot = code_len + {1'b0, dn};
        room = {1'b0, max_frame} - {1'b0, fc_next};
        fs0  = (fc_next == 24'd0) && ((kind_next != PK_FU) || hh_next[7]);
        ne   = 3'd0;
        if (pend_next == ST_NONE && ntot != 3'd0) begin
            if (room[24]) begin
                ne = 3'd0;
            end else if (room < {22'd0, ntot}) begin
                ne = room[2:0];
            end else begin
                ne = ntot;
            end
            if (ne != ntot) pend_next = ST_OVERFLOW;
        end
        fc_next = fc_next + {21'd0, ne};

        // packet status on the last byte
        if (in_last && (in_first || kind_reg != PK_IDLE)) begin
            has_status = 1'b1;
            if (pend_next != ST_NONE) st = pend_next;
            else if (kind_next == PK_SINGLE) st = ST_COMPLETE;
            else if (kind_next == PK_STAP)
                st = (ph_next == PH_DATA || fc_next == 24'd0) ? ST_BAD_LEN : ST_COMPLETE;
            else if (off_next < Off2) st = ST_BAD_LEN;
            else if (hh_next[7]) st = ST_CONTINUES;
            else st = hh_next[6] ? ST_COMPLETE : ST_CONTINUES;
            if (st != ST_CONTINUES) fc_next = '0;
            kind_next = PK_IDLE;
        end

        res_cnt = {1'b0, ne} + {3'd0, has_status};

        // result slots
        for (int k = 0; k < MaxResults; k++) begin
            idx = 3'(k) - code_len;
            res[k].kind        = KIND_BYTE;
            res[k].value       = 8'h00;
            res[k].frame_start = 1'b0;
            res[k].status      = ST_NONE;
            res[k].last        = (4'(k) + 4'd1 == res_cnt);
            if (3'(k) < ne && k < 7) begin
                if (3'(k) < code_len)
                    res[k].value = (3'(k) == code_len - 3'd1) ? 8'h01 : 8'h00;
                else
                    res[k].value = dv[idx[1:0]];
                res[k].frame_start = (k == 0) && fs0;
            end else begin
                res[k].kind   = KIND_STATUS;
                res[k].status = st;
            end
        end
    end

endmodule

[hw/rtl/h264rd_queue.sv]
// result queue: takes up to a burst of results per cycle, gives one per cycle while rd_take is high
// depends on h264rd_pkg
module h264rd_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  h264rd_pkg::res_t      wr_res [h264rd_pkg::MaxResults],
    input  logic [3:0]            wr_cnt,
    output logic                  room_ok,
    output h264rd_pkg::res_t      rd_res,
    output logic                  rd_valid,
    input  logic                  rd_take
);
    import h264rd_pkg::*;

    localparam int unsigned AW = $clog2(QueueDepth);

    res_t          mem_reg [QueueDepth];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          pop;

    assign pop      = rd_valid && rd_take;
    assign rd_valid = (cnt_reg != '0);
    assign rd_res   = mem_reg[rd_ptr_reg];
    assign room_ok  = (cnt_reg <= (AW+1)'(QueueDepth - MaxResults));
    assign cnt_next = cnt_reg + (AW+1)'(wr_cnt) - (AW+1)'(pop);

    // storage
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MaxResults; i++) begin
            if (4'(i) < wr_cnt) mem_reg[wr_ptr_reg + AW'(i)] <= wr_res[i];
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + AW'(wr_cnt);
            rd_ptr_reg <= rd_ptr_reg + AW'(pop);
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[hw/rtl/h264_rtp_depacketizer_core.sv]
// path from input transfer to first result: input register, then result queue
// throughput: one payload byte per cycle while the queue has room; each byte makes up to
// 8 results, read one per cycle while m_tready is high, so start code bursts stall input
// a held byte is stepped while the 16-entry result queue has room for 8 more results
// reset: synchronous active-low, clears parser state and queue; limit back to 1048576
// top level; depends on h264rd_pkg, h264rd_parse, h264rd_queue and the macro header
`include "h264_rtp_depacketizer_core_macros.svh"
module h264_rtp_depacketizer_core #(
    parameter int unsigned PACKET_OFFSET_BITS = h264rd_pkg::OffsetBitsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] in_first
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_value, [8] frame_start, [11:9] packet_status
    output logic        m_tuser,   // [0] out_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data
);
    import h264rd_pkg::*;

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg, in_last_reg;
    logic [23:0] max_reg;
    logic        step, room_ok;
    res_t        res [MaxResults];
    logic [3:0]  res_cnt;
    res_t        out_res;

    assign step      = in_vld_reg && room_ok;
    assign s_tready  = !in_vld_reg || step;
    assign cfg_ready = 1'b1;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    // frame size limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= MaxFrameReset;
        end else if (cfg_valid && cfg_ready) begin
            max_reg <= cfg_data;
        end
    end

    h264rd_parse #(
        .PACKET_OFFSET_BITS(PACKET_OFFSET_BITS)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_byte   (in_byte_reg),
        .in_first  (in_first_reg),
        .in_last   (in_last_reg),
        .max_frame (max_reg),
        .res       (res),
        .res_cnt   (res_cnt)
    );

    h264rd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_res   (res),
        .wr_cnt   (step ? res_cnt : 4'd0),
        .room_ok  (room_ok),
        .rd_res   (out_res),
        .rd_valid (m_tvalid),
        .rd_take  (m_tready)
    );

    // result packing
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;
    assign m_tdata = {4'b0000, out_res.status, out_res.frame_start, out_res.value};

    // a stepped item never makes more results than one burst
    `H264RD_ASSERT_NOW(a_res_bound, aclk, aresetn, step, res_cnt <= 4'(MaxResults))
    // a status result never carries frame data
    `H264RD_ASSERT_NOW(a_status_clean, aclk, aresetn, m_tvalid && out_res.kind == KIND_STATUS,
        out_res.value == 8'h00 && !out_res.frame_start)
    // a held input item is consumed once the queue has room
    `H264RD_ASSERT_NEXT(a_in_drain, aclk, aresetn, in_vld_reg && room_ok && !s_tvalid,
        !in_vld_reg)

endmodule

[test/h264_rtp_depacketizer_core_test.sv]
// self-checking testbench for the h264 rtp depacketizer core
// depends on h264rd_pkg and h264_rtp_depacketizer_core
`timescale 1ns / 1ps
module h264_rtp_depacketizer_core_test;
    import h264rd_pkg::*;

    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned OffsetMax  = (1 << OffsetBitsDefault) - 1;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data = '0;

    h264_rtp_depacketizer_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [23:0] frame_limit;
    pkt_kind_t   pkt_kind;
    int unsigned pkt_offset;
    logic [7:0]  fu_indicator, fu_header, unit_byte0;
    logic [15:0] entry_size, entry_left;
    agg_phase_t  agg_phase;
    logic [23:0] frame_bytes;
    logic [2:0]  pkt_error;

    res_t expected_results[$];
    res_t step_results[$];
    int   error_count = 0;
    int   cycle_count = 0;
    bit   idle_off = 1'b0;

    function automatic bit short_code(logic [7:0] b0, logic [7:0] b1);
        return (b0 == 8'h65) || ((b0 == 8'h61 || b0 == 8'h41) && !b1[7]);
    endfunction

    function automatic void push_result(logic k, logic [7:0] v, logic fs, logic [2:0] st);
        res_t r;
        if (step_results.size() >= MaxResults) return;
        r.kind = k; r.value = v; r.frame_start = fs; r.status = st; r.last = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void frame_byte(logic [7:0] v);
        logic fs;
        if (pkt_error != ST_NONE) return;
        if ({8'd0, frame_bytes} + 32'd1 > {8'd0, frame_limit}) begin
            pkt_error = ST_OVERFLOW;
            return;
        end
        fs = (frame_bytes == 0) && (pkt_kind != PK_FU || fu_header[7]);
        push_result(KIND_BYTE, v, fs, ST_NONE);
        frame_bytes = frame_bytes + 24'd1;
    endfunction

    function automatic void sync_code(bit is_short);
        if (!is_short) frame_byte(8'h00);
        frame_byte(8'h00);
        frame_byte(8'h00);
        frame_byte(8'h01);
    endfunction

    function automatic logic [7:0] nal_header();
        return (fu_indicator & 8'he0) | (fu_header & 8'h1f);
    endfunction

    function automatic void stap_byte(logic [7:0] b, bit last);
        logic [15:0] pos;
        if (agg_phase == PH_SIZE_HI) begin
            entry_size = {b, 8'h00}; agg_phase = PH_SIZE_LO;
        end else if (agg_phase == PH_SIZE_LO) begin
            entry_size = entry_size | b;
            agg_phase = PH_SIZE_HI;
            if (last) return;
            if (entry_size == 0) begin
                sync_code(1'b0);
                return;
            end
            entry_left = entry_size; agg_phase = PH_DATA;
        end else begin
            pos = entry_size - entry_left;
            if (pos == 0) begin
                unit_byte0 = b;
                if (entry_size == 1) begin
                    sync_code(short_code(b, 8'h00)); frame_byte(b);
                end
            end else if (pos == 1) begin
                sync_code(short_code(unit_byte0, b));
                frame_byte(unit_byte0); frame_byte(b);
            end else begin
                frame_byte(b);
            end
            entry_left = entry_left - 16'd1;
            if (entry_left == 0) agg_phase = PH_SIZE_HI;
        end
    endfunction

    function automatic void fu_byte(logic [7:0] b, bit last);
        if (pkt_offset == 1) begin
            fu_header = b;
            if (b[7]) frame_bytes = '0;
            return;
        end
        if (!fu_header[7]) begin
            frame_byte(b);
            return;
        end
        if (pkt_offset == 2) begin
            unit_byte0 = b;
            if (last) begin
                sync_code(short_code(b, 8'h00)); frame_byte(nal_header()); frame_byte(b);
            end
        end else if (pkt_offset == 3) begin
            sync_code(short_code(unit_byte0, b));
            frame_byte(nal_header()); frame_byte(unit_byte0); frame_byte(b);
        end else begin
            frame_byte(b);
        end
    endfunction

    // works out the results of one payload byte and queues them
    function automatic void predict_byte(logic [7:0] b, bit first, bit last);
        logic [2:0] st;
        logic [4:0] t;
        step_results.delete();
        if (first) begin
            t = b[4:0];
            pkt_offset = 0; pkt_error = ST_NONE; fu_header = '0;
            if (t <= 5'd23) begin
                pkt_kind = PK_SINGLE; frame_bytes = '0; unit_byte0 = b;
                if (last) begin
                    sync_code(short_code(b, 8'h00)); frame_byte(b);
                end
            end else if (t == NAL_STAP_A) begin
                pkt_kind = PK_STAP; frame_bytes = '0; agg_phase = PH_SIZE_HI;
                entry_size = '0; entry_left = '0;
            end else if (t == NAL_FU_A) begin
                pkt_kind = PK_FU; fu_indicator = b;
            end else begin
                pkt_kind = PK_SINGLE; frame_bytes = '0; pkt_error = ST_UNKNOWN;
            end
        end else begin
            if (pkt_kind == PK_IDLE) return;
            if (pkt_offset < OffsetMax) pkt_offset++;
            if (pkt_error == ST_NONE) begin
                if (pkt_kind == PK_SINGLE) begin
                    if (pkt_offset == 1) begin
                        sync_code(short_code(unit_byte0, b)); frame_byte(unit_byte0);
                    end
                    frame_byte(b);
                end else if (pkt_kind == PK_STAP) begin
                    stap_byte(b, last);
                end else begin
                    fu_byte(b, last);
                end
            end
        end
        if (last) begin
            if (pkt_error != ST_NONE) st = pkt_error;
            else if (pkt_kind == PK_SINGLE) st = ST_COMPLETE;
            else if (pkt_kind == PK_STAP)
                st = (agg_phase == PH_DATA || frame_bytes == 0) ? ST_BAD_LEN : ST_COMPLETE;
            else if (pkt_offset < 2) st = ST_BAD_LEN;
            else if (fu_header[7]) st = ST_CONTINUES;
            else st = fu_header[6] ? ST_COMPLETE : ST_CONTINUES;
            if (st != ST_CONTINUES) frame_bytes = '0;
            push_result(KIND_STATUS, 8'h00, 1'b0, st);
            pkt_kind = PK_IDLE;
        end
        if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
    endfunction

    function automatic void predictor_reset();
        frame_limit = MaxFrameReset;
        pkt_kind = PK_IDLE; pkt_offset = 0;
        fu_indicator = '0; fu_header = '0; unit_byte0 = '0;
        entry_size = '0; entry_left = '0; agg_phase = PH_SIZE_HI;
        frame_bytes = '0; pkt_error = ST_NONE;
    endfunction

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stall and check of every transfer
    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser; got.value = m_tdata[7:0]; got.frame_start = m_tdata[8];
            got.status = m_tdata[11:9]; got.last = m_tlast;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind)
                    $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
                if (got.value !== want.value)
                    $display("%0t: value exp %h got %h", $time, want.value, got.value);
                if (got.frame_start !== want.frame_start)
                    $display("%0t: frame_start exp %0d got %0d", $time,
                             want.frame_start, got.frame_start);
                if (got.status !== want.status)
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                if (got.last !== want.last)
                    $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
                if (got !== want) error_count++;
            end
        end
        m_tready <= idle_off || ($urandom_range(99) >= 37);
    end

    // one payload byte, with a random gap before it; valid stays up for the next byte
    task automatic send_byte(logic [7:0] b, bit first, bit last);
        while (!idle_off && $urandom_range(99) < 37) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1; s_tdata <= b; s_tuser <= first; s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_byte(b, first, last);
    endtask

    task automatic send_packet(logic [7:0] bytes[$]);
        foreach (bytes[i]) send_byte(bytes[i], i == 0, i == bytes.size() - 1);
    endtask

    // stop the input and wait for every expected result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_limit(logic [23:0] v);
        drain();
        cfg_valid <= 1'b1; cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        frame_limit = v;
    endtask

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(255));
    endfunction

    // single nal packets, start code choice and unknown types
    task automatic test_single();
        send_packet('{8'h65});
        send_packet('{8'h61, 8'h7f, 8'hff});
        send_packet('{8'h41, 8'h80});
        send_packet('{8'h00, 8'h00});
        send_packet('{8'h19, 8'haa});
        send_packet('{8'hff, 8'h12});
        send_byte(8'h55, 1'b0, 1'b1);
        send_byte(8'h67, 1'b1, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_packet('{8'h61, 8'h00});
    endtask

    // stap-a with zero-size, overrun and trailing bytes
    task automatic test_stap();
        send_packet('{8'h18, 8'h00, 8'h02, 8'h65, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h41});
        send_packet('{8'h18, 8'h00, 8'h05, 8'h61});
        send_packet('{8'h18, 8'h00});
        send_packet('{8'h18, 8'h00, 8'h01, 8'h65, 8'h00});
    endtask

    // fu-a start, middle, end and short packets
    task automatic test_fu();
        send_packet('{8'h7c, 8'h85, 8'h88, 8'h10, 8'h20});
        send_packet('{8'h7c, 8'h05, 8'h30});
        send_packet('{8'h7c, 8'h45, 8'h40});
        send_packet('{8'h5c, 8'hc1, 8'h41});
        send_packet('{8'h7c, 8'h81});
        send_packet('{8'h7c});
        send_packet('{8'h7c, 8'h41, 8'hee});
    endtask

    // frame size limit at its extremes
    task automatic test_limit();
        write_limit(24'd0);
        send_packet('{8'h65, 8'h01});
        write_limit(24'd8);
        send_packet('{8'h65, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05});
        send_packet('{8'h7c, 8'h85, 8'h01, 8'h02});
        send_packet('{8'h7c, 8'h45, 8'h03});
        write_limit(24'hffffff);
        send_packet('{8'h67, 8'h01, 8'h02});
    endtask

    task automatic random_packet();
        logic [7:0] pkt[$];
        int n, kind, esz;
        kind = $urandom_range(9);
        if (kind < 3) begin
            pkt.push_back({$urandom_range(1) ? 3'b011 : 3'($urandom_range(7)),
                           5'($urandom_range(23))});
            n = $urandom_range(6);
            repeat (n) pkt.push_back(rnd_byte());
        end else if (kind < 5) begin
            pkt.push_back({3'($urandom_range(7)), NAL_STAP_A});
            repeat ($urandom_range(3)) begin
                esz = $urandom_range(4);
                pkt.push_back(8'h00); pkt.push_back(8'(esz));
                repeat (esz) pkt.push_back($urandom_range(1) ? 8'h65 : rnd_byte());
            end
            if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) pkt.push_back(rnd_byte());
        end else if (kind < 9) begin
            pkt.push_back({3'($urandom_range(7)), NAL_FU_A});
            pkt.push_back({2'($urandom_range(3)), 1'($urandom_range(1)),
                           5'($urandom_range(31))});
            n = $urandom_range(5);
            repeat (n) pkt.push_back(($urandom_range(2) == 0) ? 8'h61 : rnd_byte());
        end else begin
            repeat ($urandom_range(1, 4)) pkt.push_back(rnd_byte());
            if ($urandom_range(1)) begin
                send_byte(rnd_byte(), 1'b0, 1'($urandom_range(1)));
                return;
            end
        end
        send_packet(pkt);
    endtask

    // random traffic under several limits
    task automatic test_random();
        write_limit(MaxFrameReset);
        repeat (30) random_packet();
        idle_off = 1'b1;
        repeat (20) random_packet();
        idle_off = 1'b0;
        // hold off until the result queue has emptied
        drain();
        write_limit(24'd12);
        repeat (25) random_packet();
        write_limit(24'd40);
        repeat (12) random_packet();
    endtask

    initial begin
        predictor_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single();
        test_stap();
        test_fu();
        test_limit();
        test_random();
        drain();
        repeat (20) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
